[sv/unsigned_to_decimal_ascii_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the unsigned to decimal ASCII converter
// Shorthand for clocked implication checks, reset-qualified on arst_n.
// ----------------------------------------------------------------------------
`ifndef UNSIGNED_TO_DECIMAL_ASCII_ASSERT_SVH
`define UNSIGNED_TO_DECIMAL_ASCII_ASSERT_SVH

// Same-cycle implication: when ante holds, cons must hold in that cycle.
`define U2DA_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication: when ante holds, cons must hold in the next cycle.
`define U2DA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/u2da_pkg.sv]
// ----------------------------------------------------------------------------
// u2da_pkg
// Shared types and constants of the binary to decimal ASCII converter.
// ----------------------------------------------------------------------------
package u2da_pkg;

	localparam int WORD_BITS   = 32;
	localparam int WORD_DIGITS = 10;
	localparam int BCD_BITS    = 4 * WORD_DIGITS;

	typedef logic [WORD_BITS-1:0] word_t;
	typedef logic [BCD_BITS-1:0]  bcd_t;
	typedef logic [3:0]           digit_t;
	typedef logic [3:0]           count_t;
	typedef logic [5:0]           char_t;

	localparam char_t  ASCII_ZERO = 6'h30;
	localparam count_t FULL_COUNT = count_t'(WORD_DIGITS);

	// Conversion result handed from the shift-and-add unit to the emitter.
	typedef struct packed {
		logic done;
		bcd_t bcd;
	} conv_res_t;

endpackage

[sv/u2da_channels.sv]
// ----------------------------------------------------------------------------
// u2da channel interfaces
// Valid/ready channels for the binary number and for the digit characters.
// ----------------------------------------------------------------------------
interface u2da_num_if;
	logic        valid;
	logic        ready;
	logic [31:0] value;

	modport source (output valid, output value, input ready);
	modport sink (input valid, input value, output ready);
endinterface

interface u2da_txt_if;
	logic       valid;
	logic       ready;
	logic [5:0] digit_char;
	logic [3:0] digit_count;
	logic       last;

	modport source (output valid, output digit_char, output digit_count, output last,
		input ready);
	modport sink (input valid, input digit_char, input digit_count, input last,
		output ready);
endinterface

[sv/u2da_dabble.sv]
// ----------------------------------------------------------------------------
// u2da_dabble
// Bit-serial binary to BCD conversion by shift and add-three.
// ----------------------------------------------------------------------------
module u2da_dabble (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  u2da_pkg::word_t   value,
	output u2da_pkg::conv_res_t res
);
	import u2da_pkg::*;

	localparam int CNT_W = $clog2(WORD_BITS);
	localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(WORD_BITS - 1);

	word_t            bin_q;
	bcd_t             bcd_q;
	logic [CNT_W-1:0] step_q;
	logic             busy_q;
	logic             done_q;
	bcd_t             bcd_adj;

	// Every BCD digit of five or more gets three added before the shift.
	always_comb begin
		for (int i = 0; i < WORD_DIGITS; i++) begin
			if (bcd_q[4*i +: 4] >= 4'd5) begin
				bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
			end else begin
				bcd_adj[4*i +: 4] = bcd_q[4*i +: 4];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= busy_q && (step_q == LAST_STEP);
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == LAST_STEP) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			bin_q <= value;
			bcd_q <= '0;
		end else if (busy_q) begin
			bcd_q <= {bcd_adj[BCD_BITS-2:0], bin_q[WORD_BITS-1]};
			bin_q <= {bin_q[WORD_BITS-2:0], 1'b0};
		end
	end

	assign res.done = done_q;
	assign res.bcd  = bcd_q;

endmodule

[sv/u2da_emit.sv]
// ----------------------------------------------------------------------------
// u2da_emit
// Strips leading zeros, limits the digit count and sends one digit a beat.
// ----------------------------------------------------------------------------
module u2da_emit #(
	parameter int MAX_DIGITS = 10
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  u2da_pkg::conv_res_t conv,
	output logic                idle,
	u2da_txt_if.source          text
);
	import u2da_pkg::*;

	localparam int LIM_I = (MAX_DIGITS < 1) ? 1 :
		((MAX_DIGITS > WORD_DIGITS) ? WORD_DIGITS : MAX_DIGITS);
	localparam count_t LIM = count_t'(LIM_I);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WAIT,
		ST_SCAN,
		ST_TRIM,
		ST_EMIT
	} state_t;

	state_t state_q;
	bcd_t   sh_q;
	count_t rem_q;
	count_t count_q;
	logic   ovalid_q;
	char_t  ochar_q;
	count_t ocount_q;
	logic   olast_q;
	digit_t top;

	assign top = sh_q[BCD_BITS-1 -: 4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			ovalid_q <= 1'b0;
			sh_q     <= '0;
			rem_q    <= '0;
			count_q  <= '0;
			ochar_q  <= ASCII_ZERO;
			ocount_q <= '0;
			olast_q  <= 1'b0;
		end else begin
			// While digits are sent, the emit arm below loads the next beat
			// whenever the current one is taken.
			if (text.ready && state_q != ST_EMIT) begin
				ovalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_WAIT;
					end
				end
				ST_WAIT: begin
					if (conv.done) begin
						sh_q    <= conv.bcd;
						rem_q   <= FULL_COUNT;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (top == 4'd0 && rem_q > 4'd1) begin
						sh_q  <= {sh_q[BCD_BITS-5:0], 4'd0};
						rem_q <= rem_q - 4'd1;
					end else begin
						state_q <= ST_TRIM;
					end
				end
				ST_TRIM: begin
					if (rem_q > LIM) begin
						sh_q  <= {sh_q[BCD_BITS-5:0], 4'd0};
						rem_q <= rem_q - 4'd1;
					end else begin
						count_q <= rem_q;
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (!ovalid_q || text.ready) begin
						ovalid_q <= 1'b1;
						ochar_q  <= ASCII_ZERO + {2'b00, top};
						ocount_q <= count_q;
						olast_q  <= (rem_q == 4'd1);
						sh_q     <= {sh_q[BCD_BITS-5:0], 4'd0};
						rem_q    <= rem_q - 4'd1;
						if (rem_q == 4'd1) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign idle             = (state_q == ST_IDLE);
	assign text.valid       = ovalid_q;
	assign text.digit_char  = ochar_q;
	assign text.digit_count = ocount_q;
	assign text.last        = olast_q;

endmodule

[sv/unsigned_to_decimal_ascii.sv]
// ----------------------------------------------------------------------------
// unsigned_to_decimal_ascii
// 32-bit unsigned binary to decimal ASCII text, most significant digit first.
// ----------------------------------------------------------------------------
//
//  Channel  Role    Payload                              Beats per number
//  number   sink    value[31:0]                          1
//  text     source  digit_char, digit_count, last        1 to 10
//
// A number passes from acceptance to the acceptance of its last digit through
// 32 shift-and-add-three steps, the hand-over of the BCD result, the leading
// zero strip, the count limit and digit loading, and the last beat. The next
// number is accepted once the final digit sits in the output register, even
// while that beat still waits on text, so a new number is not taken while the
// one before is still converted or its earlier digits are still being sent.
// Reset is asynchronous and clears all control state; stalls on text hold
// the output register and pause the digit sequence.
//
module unsigned_to_decimal_ascii #(
	parameter int MAX_DIGITS = 10
) (
	input  logic       clk,
	input  logic       arst_n,
	u2da_num_if.sink   number,
	u2da_txt_if.source text
);
	import u2da_pkg::*;

	logic      idle;
	logic      start;
	conv_res_t conv;

	// The converter only ever works on one number; a new beat is taken while
	// the emitter is idle, which also starts the BCD conversion.
	assign number.ready = idle;
	assign start        = number.valid && idle;

	u2da_dabble u_dabble (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.value  (number.value),
		.res    (conv)
	);

	// The emitter waits for the conversion, skips leading zero digits (always
	// keeping at least one), drops the most significant digits beyond the
	// configured limit, and sends the rest one beat per digit.
	u2da_emit #(
		.MAX_DIGITS (MAX_DIGITS)
	) u_emit (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.conv   (conv),
		.idle   (idle),
		.text   (text)
	);

endmodule

[sv/u2da_checker.sv]
// ----------------------------------------------------------------------------
// u2da_checker
// Port-level checks on the digit stream of the decimal converter.
// ----------------------------------------------------------------------------
`include "unsigned_to_decimal_ascii_assert.svh"

module u2da_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [5:0] digit_char,
	input logic [3:0] digit_count,
	input logic       last
);

	`U2DA_ASSERT_NEXT(a_hold_stalled, out_valid && !out_ready, out_valid && $stable(digit_char) && $stable(digit_count) && $stable(last), "stalled text beat changed")

	`U2DA_ASSERT_SAME(a_char_range, out_valid, digit_char >= 6'h30 && digit_char <= 6'h39, "digit_char outside 0 to 9")

	`U2DA_ASSERT_SAME(a_count_range, out_valid, digit_count >= 4'd1 && digit_count <= 4'd10, "digit_count outside 1 to 10")

	`U2DA_ASSERT_SAME(a_single_last, out_valid && digit_count == 4'd1, last, "one-digit run without last")

	`U2DA_ASSERT_NEXT(a_count_steady, out_valid && out_ready && !last, !out_valid || digit_count == $past(digit_count), "digit_count changed inside a run")

endmodule

bind unsigned_to_decimal_ascii u2da_checker u_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (text.valid),
	.out_ready   (text.ready),
	.digit_char  (text.digit_char),
	.digit_count (text.digit_count),
	.last        (text.last)
);
